// ===== src/fcrw_pkg.sv =====
package fcrw_pkg;

	localparam int FAT_BYTES = 65536;
	localparam int ADDR_W    = $clog2(FAT_BYTES);

	localparam logic [31:0] CHAIN_END  = 32'hFFFF_FFFF;
	localparam logic [11:0] FAT12_MASK = 12'hFFF;
	localparam logic [31:0] FAT12_END  = 32'h0000_0FF8;
	localparam logic [31:0] FAT16_END  = 32'h0000_FFF8;
	localparam logic [31:0] FAT32_END  = 32'h0FFF_FFF8;

	// action codes carried in tuser
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;

	// fat_type codes; the spare code behaves as FAT32
	localparam logic [1:0] FT_12 = 2'd0;
	localparam logic [1:0] FT_16 = 2'd1;
	localparam logic [1:0] FT_32 = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_FAT_TYPE = 3'd0;
	localparam logic [2:0] REG_SPC      = 3'd1;
	localparam logic [2:0] REG_RESERVED = 3'd2;
	localparam logic [2:0] REG_COPIES   = 3'd3;
	localparam logic [2:0] REG_SPF      = 3'd4;
	localparam logic [2:0] REG_ROOT     = 3'd5;

	localparam int PADDR_W = 5;

endpackage

// ===== src/fat_chain_run_walker_top.sv =====
// FAT cluster chain walker. The FAT image is loaded byte by byte (action 0), a chain
// is opened at a cluster (action 1), and each next-run request (action 2) returns one
// run of consecutive clusters as first sector and sector count. No new item is taken
// while a run request is in progress. A run request looks up FAT entries one after
// another, 2 bytes each for FAT12/FAT16 and 4 for FAT32, read one byte at a time through
// the single byte-wide read port of the FAT store, a 64 KiB synchronous RAM with no
// clearing pass. A lookup outside the store ends the walk; a request on an ended chain
// reads nothing. A run item still held by the receiver stalls the next request in its
// finishing state. Registers must be written by the user over the APB port only while
// no request is in progress; the block itself does not enforce this.
module fat_chain_run_walker_top import fcrw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [55:0]        s_tdata,  // byte_address[15:0], byte_value[23:16], start_cluster[55:24]
	input  logic [1:0]         s_tuser,  // action[1:0]
	// run stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,  // run_lba[31:0], run_sectors[63:32]
	output logic               m_tlast,  // last_run
	output logic [1:0]         m_tuser   // no_run[0], range_error[1]
);

	typedef enum logic [2:0] {
		S_IDLE, S_ADDR, S_READ, S_LAST, S_EVAL, S_FIN1, S_FIN2
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0]  fat_type_q;
	logic [7:0]  spc_q;
	logic [15:0] reserved_q;
	logic [2:0]  copies_q;
	logic [31:0] spf_q;
	logic [15:0] root_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_type_q <= FT_16;
			spc_q      <= 8'd1;
			reserved_q <= 16'd1;
			copies_q   <= 3'd2;
			spf_q      <= 32'd0;
			root_q     <= 16'd0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FAT_TYPE: fat_type_q <= pwdata[1:0];
				REG_SPC:      spc_q      <= pwdata[7:0];
				REG_RESERVED: reserved_q <= pwdata[15:0];
				REG_COPIES:   copies_q   <= pwdata[2:0];
				REG_SPF:      spf_q      <= pwdata;
				REG_ROOT:     root_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FAT_TYPE: prdata = {30'd0, fat_type_q};
			REG_SPC:      prdata = {24'd0, spc_q};
			REG_RESERVED: prdata = {16'd0, reserved_q};
			REG_COPIES:   prdata = {29'd0, copies_q};
			REG_SPF:      prdata = spf_q;
			REG_ROOT:     prdata = {16'd0, root_q};
			default:      prdata = 32'd0;
		endcase
	end

	// request fields
	logic [1:0]  in_action;
	logic [15:0] in_addr;
	logic [7:0]  in_value;
	logic [31:0] in_start;
	logic        s_acc;

	assign in_action = s_tuser;
	assign in_addr   = s_tdata[15:0];
	assign in_value  = s_tdata[23:16];
	assign in_start  = s_tdata[55:24];
	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;

	// walk state
	logic [31:0]       cur_q;     // current_cluster
	logic [31:0]       base_q;    // first cluster of the run
	logic [31:0]       walk_q;    // cluster whose entry is looked up
	logic [31:0]       cnt_q;
	logic [31:0]       nxt_q;
	logic              fault_q;
	logic              no_run_q;
	logic [ADDR_W-1:0] off_q;
	logic [1:0]        byte_idx_q;
	logic [31:0]       entry_q;
	logic              pend_s1;
	logic [1:0]        pend_idx_s1;
	logic [31:0]       prod_lba_q;
	logic [31:0]       prod_sec_q;
	logic [31:0]       dlba_q;

	logic              m_tvalid_q;
	logic [31:0]       run_lba_q;
	logic [31:0]       run_sectors_q;
	logic              last_run_q;
	logic              out_no_run_q;
	logic              range_error_q;

	// RAM
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	assign ram_we    = s_acc && (in_action == ACT_WRITE) && ({16'd0, in_addr} < 32'(FAT_BYTES));
	assign ram_re    = (state_q == S_READ);
	assign ram_raddr = off_q + ADDR_W'(byte_idx_q);

	fcrw_ram #(
		.WIDTH(8),
		.DEPTH(FAT_BYTES)
	) u_fat_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_addr[ADDR_W-1:0]),
		.wdata(in_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// entry offset and range check
	logic        wide_entry;
	logic [1:0]  last_idx;
	logic [33:0] off;
	logic [34:0] off_end;
	logic        fault;

	assign wide_entry = !((fat_type_q == FT_12) || (fat_type_q == FT_16));
	assign last_idx   = wide_entry ? 2'd3 : 2'd1;

	always_comb begin
		case (fat_type_q)
			FT_12:   off = {2'b00, walk_q} + {3'b000, walk_q[31:1]};
			FT_16:   off = {1'b0, walk_q, 1'b0};
			default: off = {walk_q, 2'b00};
		endcase
	end

	// one past the last byte of the entry
	assign off_end = {1'b0, off} + {33'd0, last_idx} + 35'd1;
	assign fault   = (off_end > 35'(FAT_BYTES)) || (off_end < {1'b0, off});

	// entry decode
	logic [31:0] raw12;
	logic [31:0] val;
	logic [31:0] limit;
	logic        eoc;
	logic [31:0] expect_nxt;

	assign raw12 = walk_q[0] ? (entry_q >> 4) : entry_q;

	always_comb begin
		case (fat_type_q)
			FT_12: begin
				val   = {20'd0, raw12[11:0] & FAT12_MASK};
				limit = FAT12_END;
			end
			FT_16: begin
				val   = {16'd0, entry_q[15:0]};
				limit = FAT16_END;
			end
			default: begin
				val   = {4'd0, entry_q[27:0]};
				limit = FAT32_END;
			end
		endcase
	end

	assign eoc        = (val >= limit);
	assign expect_nxt = base_q + cnt_q;

	// sector arithmetic
	logic [31:0] base_m2;
	logic [39:0] mul_lba;
	logic [39:0] mul_sec;
	logic [34:0] mul_fat;
	logic [11:0] root_secs;

	assign base_m2   = base_q - 32'd2;
	assign mul_lba   = base_m2 * spc_q;
	assign mul_sec   = cnt_q * spc_q;
	assign mul_fat   = copies_q * spf_q;
	assign root_secs = wide_entry ? 12'd0 : root_q[15:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= CHAIN_END;
			pend_s1      <= 1'b0;
			m_tvalid_q   <= 1'b0;
			fault_q      <= 1'b0;
			no_run_q     <= 1'b0;
		end else begin
			// the finishing state reloads the output slot itself
			if (m_tvalid_q && m_tready && (state_q != S_FIN2)) begin
				m_tvalid_q <= 1'b0;
			end

			pend_s1 <= (state_q == S_READ);
			if (pend_s1) begin
				case (pend_idx_s1)
					2'd0:    entry_q[7:0]   <= ram_rdata;
					2'd1:    entry_q[15:8]  <= ram_rdata;
					2'd2:    entry_q[23:16] <= ram_rdata;
					default: entry_q[31:24] <= ram_rdata;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (in_action == ACT_START) begin
							cur_q <= wide_entry ? in_start : {16'd0, in_start[15:0]};
						end else if (in_action == ACT_NEXT) begin
							base_q   <= cur_q;
							walk_q   <= cur_q;
							cnt_q    <= 32'd1;
							fault_q  <= 1'b0;
							no_run_q <= (cur_q == CHAIN_END);
							state_q  <= (cur_q == CHAIN_END) ? S_FIN2 : S_ADDR;
						end
					end
				end
				S_ADDR: begin
					if (fault) begin
						fault_q <= 1'b1;
						nxt_q   <= CHAIN_END;
						state_q <= S_FIN1;
					end else begin
						off_q      <= off[ADDR_W-1:0];
						byte_idx_q <= 2'd0;
						entry_q    <= 32'd0;
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					pend_idx_s1 <= byte_idx_q;
					byte_idx_q  <= byte_idx_q + 2'd1;
					if (byte_idx_q == last_idx) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!eoc && (val == expect_nxt)) begin
						cnt_q   <= cnt_q + 32'd1;
						walk_q  <= val;
						state_q <= S_ADDR;
					end else begin
						nxt_q   <= eoc ? CHAIN_END : val;
						state_q <= S_FIN1;
					end
				end
				S_FIN1: begin
					prod_lba_q <= mul_lba[31:0];
					prod_sec_q <= mul_sec[31:0];
					dlba_q     <= mul_fat[31:0] + {16'd0, reserved_q} + {20'd0, root_secs};
					cur_q      <= nxt_q;
					state_q    <= S_FIN2;
				end
				S_FIN2: begin
					// wait for the output slot to free up
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q    <= 1'b1;
						out_no_run_q  <= no_run_q;
						if (no_run_q) begin
							run_lba_q     <= 32'd0;
							run_sectors_q <= 32'd0;
							last_run_q    <= 1'b0;
							range_error_q <= 1'b0;
						end else begin
							run_lba_q     <= dlba_q + prod_lba_q;
							run_sectors_q <= prod_sec_q;
							last_run_q    <= (cur_q == CHAIN_END);
							range_error_q <= fault_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {run_sectors_q, run_lba_q};
	assign m_tlast  = last_run_q;
	assign m_tuser  = {range_error_q, out_no_run_q};

endmodule

// ===== src/fcrw_ram.sv =====
module fcrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/fcrw_chk.sv =====
module fcrw_chk import fcrw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// a stalled run item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("run item changed while stalled");

	// an ended chain reports an empty run and nothing else
	a_no_run_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 64'd0) && !m_tlast && !m_tuser[1])
		else $error("no_run item carries a run");

	// a lookup outside the store ends the chain
	a_range_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("range error without end of chain");

	// a result only appears after the block was busy with a request
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a request in progress");

endmodule

bind fat_chain_run_walker_top fcrw_chk u_fcrw_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

// ===== tb/tb_fat_chain_run_walker_top.sv =====
`timescale 1ns / 100ps

module tb_fat_chain_run_walker_top;
	import fcrw_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;  // ignored by the block
	localparam logic [1:0] FT_SPARE  = 2'd3;  // decodes as FAT32
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 8;
	localparam int TAIL        = 40;
	localparam int MAX_SHOWN   = 10;
	localparam int WALK_CAP    = 256;

	typedef struct packed {
		logic [31:0] lba;
		logic [31:0] sectors;
		logic        last;
		logic        ended;
		logic        fault;
	} run_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [31:0]        pwdata   = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [55:0]        s_tdata  = '0;  // byte_address[15:0], byte_value[23:16], start_cluster[55:24]
	logic [1:0]         s_tuser  = '0;  // action[1:0]
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [63:0]        m_tdata;        // run_lba[31:0], run_sectors[63:32]
	logic               m_tlast;        // last_run
	logic [1:0]         m_tuser;        // no_run[0], range_error[1]

	fat_chain_run_walker_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the block: registers, FAT image, open chain
	logic [1:0]  cfg_type   = FT_16;
	logic [7:0]  cfg_spc    = 8'd1;
	logic [15:0] cfg_resv   = 16'd1;
	logic [2:0]  cfg_copies = 3'd2;
	logic [31:0] cfg_spf    = '0;
	logic [15:0] cfg_root   = '0;
	logic [7:0]  fat_img [0:FAT_BYTES-1];
	bit          img_written [0:FAT_BYTES-1];
	logic [31:0] chain_at = CHAIN_END;
	run_t        runs_due [$];

	int mismatches  = 0;
	int items_sent  = 0;
	int gap_pct     = 0;
	int stall_pct   = 0;
	int hold_left   = 0;
	int idle_cycles = 0;
	int cfg_round   = 0;

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("%0t %s: expected %h got %h", $time, what, want, got);
		end
	endfunction

	// one FAT lookup; clean drops if a byte never written would be read
	function automatic logic [31:0] next_entry(input logic [31:0] c, inout bit fault,
			inout bit clean);
		logic [33:0] off;
		logic [31:0] v;
		logic [31:0] lim;
		int nb;
		int idx;
		if (cfg_type == FT_12) begin
			off = 34'(c) + 34'(c >> 1);
			nb = 2;
		end else if (cfg_type == FT_16) begin
			off = 34'(c) << 1;
			nb = 2;
		end else begin
			off = 34'(c) << 2;
			nb = 4;
		end
		if (off + 34'(nb) > 34'(FAT_BYTES)) begin
			fault = 1'b1;
			return CHAIN_END;
		end
		v = '0;
		for (int i = 0; i < nb; i++) begin
			idx = int'(off) + i;
			if (!img_written[idx])
				clean = 1'b0;
			v = v | (32'(fat_img[idx]) << (8 * i));
		end
		if (cfg_type == FT_12) begin
			if (c[0])
				v = v >> 4;
			v = v & 32'(FAT12_MASK);
			lim = FAT12_END;
		end else if (cfg_type == FT_16) begin
			lim = FAT16_END;
		end else begin
			v = v & 32'h0FFF_FFFF;
			lim = FAT32_END;
		end
		return (v >= lim) ? CHAIN_END : v;
	endfunction

	function automatic void plan_run(input logic [31:0] cur, output run_t r,
			output logic [31:0] nxt, output bit clean, output int steps);
		bit fault;
		logic [31:0] cnt;
		logic [31:0] base;
		fault = 1'b0;
		clean = 1'b1;
		cnt = 32'd1;
		steps = 1;
		nxt = next_entry(cur, fault, clean);
		while (nxt != CHAIN_END && nxt == cur + cnt && steps <= WALK_CAP) begin
			cnt++;
			steps++;
			nxt = next_entry(nxt, fault, clean);
		end
		base = 32'(cfg_copies) * cfg_spf + 32'(cfg_resv);
		if (cfg_type < FT_32)
			base = base + 32'(cfg_root >> 4);
		r.lba = base + (cur - 32'd2) * 32'(cfg_spc);
		r.sectors = cnt * 32'(cfg_spc);
		r.last = (nxt == CHAIN_END);
		r.ended = 1'b0;
		r.fault = fault;
	endfunction

	// applied at the edge where the block takes the item
	function automatic void note_item(logic [1:0] act, logic [15:0] addr, logic [7:0] val,
			logic [31:0] sc);
		run_t r;
		logic [31:0] nx;
		bit clean;
		int steps;
		case (act)
			ACT_WRITE: begin
				fat_img[addr] = val;
				img_written[addr] = 1'b1;
			end
			ACT_START: begin
				chain_at = (cfg_type < FT_32) ? {16'h0, sc[15:0]} : sc;
			end
			ACT_NEXT: begin
				if (chain_at == CHAIN_END) begin
					r = '{lba: '0, sectors: '0, last: 1'b0, ended: 1'b1, fault: 1'b0};
				end else begin
					plan_run(chain_at, r, nx, clean, steps);
					chain_at = nx;
				end
				runs_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] reg_shadow(logic [2:0] idx);
		case (idx)
			REG_FAT_TYPE: return 32'(cfg_type);
			REG_SPC:      return 32'(cfg_spc);
			REG_RESERVED: return 32'(cfg_resv);
			REG_COPIES:   return 32'(cfg_copies);
			REG_SPF:      return cfg_spf;
			REG_ROOT:     return 32'(cfg_root);
			default:      return '0;
		endcase
	endfunction

	function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi);
		case ($urandom_range(2))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	// receiver: random stalls, or a long hold-off counted down here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		run_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (runs_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t unexpected run item %h", $time, m_tdata);
			end else begin
				want = runs_due.pop_front();
				check_field("run_lba", want.lba, m_tdata[31:0]);
				check_field("run_sectors", want.sectors, m_tdata[63:32]);
				check_field("last_run", 32'(want.last), 32'(m_tlast));
				check_field("no_run", 32'(want.ended), 32'(m_tuser[0]));
				check_field("range_error", 32'(want.fault), 32'(m_tuser[1]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] act, logic [15:0] addr, logic [7:0] val,
			logic [31:0] sc);
		int gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {sc, val, addr};
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		note_item(act, addr, val, sc);
	endtask

	task automatic send_write(logic [15:0] addr, logic [7:0] val);
		send_item(ACT_WRITE, addr, val, $urandom);
	endtask

	task automatic send_start(logic [31:0] sc);
		send_item(ACT_START, 16'($urandom), 8'($urandom), sc);
	endtask

	// a request that would walk unwritten FAT bytes, or more than WALK_CAP entries, is left out
	task automatic send_request;
		run_t r;
		logic [31:0] nx;
		bit clean;
		int steps;
		clean = 1'b1;
		steps = 0;
		if (chain_at != CHAIN_END)
			plan_run(chain_at, r, nx, clean, steps);
		if (clean && steps <= WALK_CAP)
			send_item(ACT_NEXT, 16'($urandom), 8'($urandom), $urandom);
	endtask

	// FAT12 entries share bytes, so the neighbour nibble is kept from the image
	task automatic write_fat_entry(logic [31:0] c, logic [31:0] value);
		logic [31:0] v;
		logic [7:0] b0;
		logic [7:0] b1;
		int off;
		v = value;
		if (cfg_type == FT_12) begin
			off = int'(c) + int'(c >> 1);
			b0 = fat_img[off];
			b1 = fat_img[off + 1];
			if (!c[0]) begin
				b0 = v[7:0];
				b1 = {b1[7:4], v[11:8]};
			end else begin
				b0 = {v[3:0], b0[3:0]};
				b1 = v[11:4];
			end
			send_write(16'(off), b0);
			send_write(16'(off + 1), b1);
		end else if (cfg_type == FT_16) begin
			off = int'(c) * 2;
			send_write(16'(off), v[7:0]);
			send_write(16'(off + 1), v[15:8]);
		end else begin
			v[31:28] = 4'($urandom);
			off = int'(c) * 4;
			for (int i = 0; i < 4; i++)
				send_write(16'(off + i), v[8*i +: 8]);
		end
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		while (runs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FAT_TYPE: cfg_type = val[1:0];
			REG_SPC:      cfg_spc = val[7:0];
			REG_RESERVED: cfg_resv = val[15:0];
			REG_COPIES:   cfg_copies = val[2:0];
			REG_SPF:      cfg_spf = val;
			REG_ROOT:     cfg_root = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic check_registers;
		for (int i = REG_FAT_TYPE; i <= REG_ROOT; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {3'(i), 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			check_field($sformatf("register %0d", i), reg_shadow(3'(i)), prdata);
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic configure(logic [1:0] ftype, logic [7:0] spc, logic [15:0] resv,
			logic [2:0] copies, logic [31:0] spf, logic [15:0] root);
		wait_drained;
		reg_write(REG_FAT_TYPE, 32'(ftype));
		reg_write(REG_SPC, 32'(spc));
		reg_write(REG_RESERVED, 32'(resv));
		reg_write(REG_COPIES, 32'(copies));
		reg_write(REG_SPF, spf);
		reg_write(REG_ROOT, 32'(root));
		check_registers;
	endtask

	task automatic random_config;
		configure(2'(cfg_round % 4), 8'(pick_value(1, 128)), 16'(pick_value(0, 65535)),
			3'(pick_value(1, 4)), pick_value(0, 32'hFFFF_FFFF), 16'(pick_value(0, 65535)));
		cfg_round++;
	endtask

	// lay a chain of up to four runs into the FAT, open it and request that many runs plus up to two more
	task automatic load_and_walk_file;
		logic [31:0] clist [$];
		logic [31:0] top;
		logic [31:0] c;
		logic [31:0] endv;
		logic [31:0] sc;
		int runs;
		int len;
		top = (cfg_type == FT_12) ? 32'd4087 : (cfg_type == FT_16) ? 32'd32767 : 32'd16383;
		case ($urandom_range(19))
			0:       c = $urandom_range(1, 0);
			1:       c = $urandom_range(top, top - 20);
			default: c = $urandom_range(top - 40, 2);
		endcase
		runs = $urandom_range(4, 1);
		for (int r = 0; r < runs; r++) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : $urandom_range(5, 1);
			for (int j = 0; j < len && c <= top; j++) begin
				clist.push_back(c);
				c++;
			end
			c = $urandom_range(top - 16, 2);
		end
		if ($urandom_range(9) < 2 && cfg_type != FT_12)
			endv = (cfg_type == FT_16) ? $urandom_range(32'hFFF7, 32768)
				: $urandom_range(32'h0FFF_FFF7, 16384);
		else if (cfg_type == FT_12)
			endv = $urandom_range(32'hFFF, 32'hFF8);
		else if (cfg_type == FT_16)
			endv = $urandom_range(32'hFFFF, 32'hFFF8);
		else
			endv = $urandom_range(32'h0FFF_FFFF, 32'h0FFF_FFF8);
		for (int i = 0; i < clist.size(); i++)
			write_fat_entry(clist[i], (i + 1 < clist.size()) ? clist[i + 1] : endv);
		sc = clist[0];
		if (cfg_type < FT_32)
			sc[31:16] = 16'($urandom);
		send_start(sc);
		repeat (runs + $urandom_range(2, 0))
			send_request;
	endtask

	task automatic send_noise;
		case ($urandom_range(9))
			0, 1, 2, 3: send_write(16'($urandom), 8'($urandom));
			4:          send_item(ACT_SPARE, 16'($urandom), 8'($urandom), $urandom);
			5, 6:       send_start($urandom);
			default:    send_request;
		endcase
	endtask

	task automatic test_registers;
		check_registers;
	endtask

	// reset settings: FAT16, fragmented chain, high start bits, range fault
	task automatic test_directed;
		send_request;
		send_item(ACT_SPARE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		write_fat_entry(2, 3);
		write_fat_entry(3, 7);
		write_fat_entry(7, 32'hFFFF);
		send_start(32'hABCD_0002);
		repeat (3) send_request;
		send_start(32'h0000_8000);
		send_request;
		send_write(16'hFFFF, 8'hA5);
	endtask

	// large settings with FAT12 odd and even entries, then the spare type
	task automatic test_extremes;
		configure(FT_12, 8'd128, 16'hFFFF, 3'd4, 32'hFFFF_FFFF, 16'hFFFF);
		write_fat_entry(3, 4);
		write_fat_entry(4, 9);
		write_fat_entry(9, 32'hFFF);
		send_start(3);
		repeat (2) send_request;
		send_start(32'h0000_FFFF);
		send_request;
		configure(FT_SPARE, 8'd1, 16'd0, 3'd1, 32'd0, 16'd0);
		write_fat_entry(1, 2);
		write_fat_entry(2, 32'h0FFF_FFFF);
		send_start(1);
		send_request;
		send_start(32'hFFFF_FFFF);
		send_request;
	endtask

	task automatic test_random(int sender_idle, int receiver_idle, int count);
		int target;
		gap_pct = sender_idle;
		stall_pct = receiver_idle;
		for (int half = 0; half < 2; half++) begin
			random_config;
			target = items_sent + count / 2;
			while (items_sent < target) begin
				if ($urandom_range(9) < 3)
					send_noise;
				load_and_walk_file;
			end
		end
	endtask

	// output held off while the sender keeps offering, so the input backs up
	task automatic test_hold_off;
		wait_drained;
		gap_pct = 0;
		stall_pct = 0;
		hold_left <= 400;
		load_and_walk_file;
		repeat (30) send_request;
		wait_drained;
	endtask

	initial begin
		for (int i = 0; i < FAT_BYTES; i++)
			fat_img[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_registers;
		test_directed;
		test_extremes;
		test_random(0, 0, 300);
		test_random(81, 0, 300);
		test_random(0, 81, 300);
		test_random(11, 11, 300);
		test_hold_off;
		wait_drained;
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && runs_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
